// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked at every rising edge outside reset
`define ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- design/sdci_pkg.sv -----
// ----------------------------------------------------------------------------
// SD card init sequencer package
// Transaction types, action and command codes, phase encoding and config.
// ----------------------------------------------------------------------------
package sdci_pkg;

    // Input transaction opcodes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_RESULT = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // Host actions
    localparam logic [2:0] ACT_HOST_RESET = 3'd0;
    localparam logic [2:0] ACT_SET_CLOCK = 3'd1;
    localparam logic [2:0] ACT_INIT_CLOCKS = 3'd2;
    localparam logic [2:0] ACT_ISSUE_CMD = 3'd3;
    localparam logic [2:0] ACT_CMD_LINE_RESET = 3'd4;
    localparam logic [2:0] ACT_WIDTH4 = 3'd5;
    localparam logic [2:0] ACT_DONE = 3'd6;
    localparam logic [2:0] ACT_FAILED = 3'd7;

    // Response kinds
    localparam logic [1:0] RK_NONE = 2'd0;
    localparam logic [1:0] RK_136 = 2'd1;
    localparam logic [1:0] RK_48 = 2'd2;
    localparam logic [1:0] RK_48_BUSY = 2'd3;

    // SD command indexes
    localparam logic [5:0] CMD_GO_IDLE = 6'd0;
    localparam logic [5:0] CMD_ALL_SEND_CID = 6'd2;
    localparam logic [5:0] CMD_SEND_RCA = 6'd3;
    localparam logic [5:0] CMD_SET_BUS_WIDTH = 6'd6;
    localparam logic [5:0] CMD_SELECT_CARD = 6'd7;
    localparam logic [5:0] CMD_SEND_IF_COND = 6'd8;
    localparam logic [5:0] CMD_SET_BLOCKLEN = 6'd16;
    localparam logic [5:0] CMD_SEND_OP_COND = 6'd41;
    localparam logic [5:0] CMD_APP_CMD = 6'd55;

    // Command arguments and response bits
    localparam logic [31:0] IF_COND_ARG = 32'h0000_01AA;
    localparam logic [7:0] CHECK_PATTERN = 8'hAA;
    localparam logic [31:0] OCR_CCS = 32'h4000_0000;
    localparam logic [31:0] BUS_WIDTH4_ARG = 32'h0000_0002;
    localparam int OCR_READY_BIT = 31;
    localparam int OCR_CCS_BIT = 30;
    localparam logic [15:0] BUSY_MS_MAX = 16'hFFFF;

    // Result list depth
    localparam int LIST_DEPTH = 4;
    localparam int LIST_IDX_W = 2;
    localparam int LIST_CNT_W = 3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BUS_CLOCK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDENT_CLOCK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSFER_CLOCK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_WINDOW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OP_COND_TIMEOUT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH = 3'd5;

    // Configuration reset values
    localparam logic [31:0] BUS_CLOCK_RST = 32'd600_000_000;
    localparam logic [25:0] IDENT_CLOCK_RST = 26'd400_000;
    localparam logic [25:0] TRANSFER_CLOCK_RST = 26'd25_000_000;
    localparam logic [23:0] VOLTAGE_WINDOW_RST = 24'hFF_8000;
    localparam logic [15:0] OP_COND_TIMEOUT_RST = 16'd2000;
    localparam logic [11:0] BLOCK_LENGTH_RST = 12'd512;

    // Clock search limits
    localparam logic [3:0] PRE_SHIFT_MAX = 4'd8;
    localparam logic [4:0] DIVISOR_MAX = 5'd16;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        cmd_failed;
        logic [31:0] response_word;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [5:0]  cmd_index;
        logic [31:0] cmd_argument;
        logic [1:0]  response_kind;
        logic        check_index;
        logic        check_crc;
        logic [8:0]  clock_prescaler;
        logic [4:0]  clock_divisor;
        logic        high_capacity;
        logic [15:0] card_address;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [31:0] bus_clock_hz;
        logic [25:0] ident_clock_hz;
        logic [25:0] transfer_clock_hz;
        logic [23:0] voltage_window;
        logic [15:0] op_cond_timeout_ms;
        logic [11:0] block_length;
    } cfg_t;

    // Result plan of one transaction, from phase control to the top level
    typedef struct packed {
        logic [LIST_CNT_W-1:0] count;
        logic                  need_clk;
        logic [LIST_IDX_W-1:0] clk_slot;
        logic [25:0]           clk_target;
    } plan_t;

    // Card identification phase
    typedef enum logic [14:0] {
        PH_IDLE   = 15'h0001,
        PH_CMD0   = 15'h0002,
        PH_WAIT2  = 15'h0004,
        PH_CMD8   = 15'h0008,
        PH_APP41  = 15'h0010,
        PH_ACMD41 = 15'h0020,
        PH_RETRY  = 15'h0040,
        PH_CMD2   = 15'h0080,
        PH_CMD3   = 15'h0100,
        PH_CMD7   = 15'h0200,
        PH_APP6   = 15'h0400,
        PH_ACMD6  = 15'h0800,
        PH_CMD16  = 15'h1000,
        PH_DONE   = 15'h2000,
        PH_FAILED = 15'h4000
    } phase_t;

endpackage

// ----- design/sd_card_init_sequencer_unit.sv -----
// Results of an accepted transaction are loaded into the result queue; a set-clock result
// first runs the clock search (prescaler doubling then divisor count on one comparator).
// Results then leave one per cycle through the output register, up to 4 per transaction,
// while the output is not stalled. item_ready is low from accept until the last result
// is loaded; a transaction with no results keeps it high.
// Reset: rst_n is asynchronous, active low; config returns to defaults, phase to idle.
// ----------------------------------------------------------------------------
// SD card init sequencer
// Sequences SD card identification and emits host actions for each step.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sd_card_init_sequencer_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  sdci_pkg::in_item_t                item,
    output logic                              result_valid,
    input  logic                              result_ready,
    output sdci_pkg::out_item_t               result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sdci_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                       cfg_data
);

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_CALC = 3'b010,
        T_EMIT = 3'b100
    } top_state_t;

    top_state_t state_reg, state_next;
    sdci_pkg::cfg_t cfg_reg;
    sdci_pkg::out_item_t [sdci_pkg::LIST_DEPTH-1:0] queue_reg, queue_next;
    sdci_pkg::out_item_t [sdci_pkg::LIST_DEPTH-1:0] list;
    logic [sdci_pkg::LIST_CNT_W-1:0] count_reg, count_next;
    logic [sdci_pkg::LIST_IDX_W-1:0] slot_reg, slot_next;
    sdci_pkg::plan_t plan;
    logic out_valid_reg, out_valid_next;
    sdci_pkg::out_item_t out_item_reg, out_item_next;
    logic accept;
    logic emit_ok;
    logic calc_start;
    logic calc_done;
    logic [8:0] calc_prescaler;
    logic [4:0] calc_divisor;

    assign item_ready = (state_reg == T_IDLE);
    assign accept = item_valid && item_ready;
    assign emit_ok = (state_reg == T_EMIT) && (!out_valid_reg || result_ready);
    assign calc_start = accept && plan.need_clk;
    assign cfg_ready = 1'b1;
    assign result_valid = out_valid_reg;
    assign result = out_item_reg;

    sdci_phase_ctrl u_phase (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (accept),
        .item  (item),
        .cfg   (cfg_reg),
        .plan  (plan),
        .list  (list)
    );

    sdci_clock_calc u_clock (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (calc_start),
        .bus_clock_hz (cfg_reg.bus_clock_hz),
        .target_clock (plan.clk_target),
        .done         (calc_done),
        .prescaler    (calc_prescaler),
        .divisor      (calc_divisor)
    );

    // Load, fill and drain the result queue
    always_comb
    begin
        state_next = state_reg;
        queue_next = queue_reg;
        count_next = count_reg;
        slot_next = slot_reg;
        unique case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    queue_next = list;
                    count_next = plan.count;
                    slot_next = plan.clk_slot;
                    if (plan.need_clk)
                    begin
                        state_next = T_CALC;
                    end
                    else if (plan.count != '0)
                    begin
                        state_next = T_EMIT;
                    end
                end
            end
            T_CALC:
            begin
                if (calc_done)
                begin
                    queue_next[slot_reg].clock_prescaler = calc_prescaler;
                    queue_next[slot_reg].clock_divisor = calc_divisor;
                    state_next = T_EMIT;
                end
            end
            T_EMIT:
            begin
                if (emit_ok)
                begin
                    for (int i = 0; i < sdci_pkg::LIST_DEPTH - 1; i++)
                    begin
                        queue_next[i] = queue_reg[i+1];
                    end
                    queue_next[sdci_pkg::LIST_DEPTH-1] = '0;
                    count_next = count_reg - 3'd1;
                    if (count_reg == 3'd1)
                    begin
                        state_next = T_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    // Move the head of the queue into the output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next = out_item_reg;
        if (emit_ok)
        begin
            out_valid_next = 1'b1;
            out_item_next = queue_reg[0];
            out_item_next.last = (count_reg == 3'd1);
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            count_reg <= '0;
            slot_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            slot_reg <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        queue_reg <= queue_next;
        out_item_reg <= out_item_next;
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bus_clock_hz <= sdci_pkg::BUS_CLOCK_RST;
            cfg_reg.ident_clock_hz <= sdci_pkg::IDENT_CLOCK_RST;
            cfg_reg.transfer_clock_hz <= sdci_pkg::TRANSFER_CLOCK_RST;
            cfg_reg.voltage_window <= sdci_pkg::VOLTAGE_WINDOW_RST;
            cfg_reg.op_cond_timeout_ms <= sdci_pkg::OP_COND_TIMEOUT_RST;
            cfg_reg.block_length <= sdci_pkg::BLOCK_LENGTH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sdci_pkg::CFG_BUS_CLOCK:       cfg_reg.bus_clock_hz <= cfg_data;
                sdci_pkg::CFG_IDENT_CLOCK:     cfg_reg.ident_clock_hz <= cfg_data[25:0];
                sdci_pkg::CFG_TRANSFER_CLOCK:  cfg_reg.transfer_clock_hz <= cfg_data[25:0];
                sdci_pkg::CFG_VOLTAGE_WINDOW:  cfg_reg.voltage_window <= cfg_data[23:0];
                sdci_pkg::CFG_OP_COND_TIMEOUT: cfg_reg.op_cond_timeout_ms <= cfg_data[15:0];
                sdci_pkg::CFG_BLOCK_LENGTH:    cfg_reg.block_length <= cfg_data[11:0];
                default:                       cfg_reg <= cfg_reg;
            endcase
        end
    end

    `ASSERT_IMP(a_idle_empty, clk, rst_n, state_reg == T_IDLE, count_reg == '0)
    `ASSERT_IMP(a_emit_nonempty, clk, rst_n, state_reg == T_EMIT, count_reg != '0)
    `ASSERT_IMP(a_clock_pow2, clk, rst_n, result_valid && (result.action == sdci_pkg::ACT_SET_CLOCK), $onehot(result.clock_prescaler))

endmodule

// ----- design/sdci_clock_calc.sv -----
// ----------------------------------------------------------------------------
// SD card clock calculator
// Iterative search for prescaler and divisor with one shared comparator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sdci_clock_calc (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] bus_clock_hz,
    input  logic [25:0] target_clock,
    output logic        done,
    output logic [8:0]  prescaler,
    output logic [4:0]  divisor
);

    localparam logic [4:0] DIVISOR_MAX_L = sdci_pkg::DIVISOR_MAX;

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_PRE  = 3'b010,
        C_DIV  = 3'b100
    } calc_state_t;

    calc_state_t state_reg, state_next;
    logic [3:0]  shift_reg, shift_next;
    logic [31:0] quot_reg, quot_next;
    logic [26:0] step_reg, step_next;
    logic [31:0] acc_reg, acc_next;
    logic [4:0]  div_reg, div_next;
    logic [31:0] cmp_rhs;
    logic        cmp_ge;

    // Shared comparator: quotient against target+1 or the divisor multiple
    assign cmp_rhs = (state_reg == C_PRE) ? {5'd0, step_reg} : acc_reg;
    assign cmp_ge = (quot_reg >= cmp_rhs);

    assign prescaler = 9'd1 << shift_reg;
    assign divisor = div_reg;
    assign done = (state_reg == C_DIV) && !((div_reg < DIVISOR_MAX_L) && cmp_ge);

    // Advance the search one step a cycle
    always_comb
    begin
        state_next = state_reg;
        shift_next = shift_reg;
        quot_next = quot_reg;
        step_next = step_reg;
        acc_next = acc_reg;
        div_next = div_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    shift_next = 4'd1;
                    quot_next = bus_clock_hz >> 1;
                    step_next = {1'b0, target_clock} + 27'd1;
                    state_next = C_PRE;
                end
            end
            C_PRE:
            begin
                if ((shift_reg < sdci_pkg::PRE_SHIFT_MAX) && cmp_ge)
                begin
                    shift_next = shift_reg + 4'd1;
                    quot_next = quot_reg >> 1;
                end
                else
                begin
                    div_next = 5'd1;
                    acc_next = {5'd0, step_reg};
                    state_next = C_DIV;
                end
            end
            C_DIV:
            begin
                if ((div_reg < DIVISOR_MAX_L) && cmp_ge)
                begin
                    div_next = div_reg + 5'd1;
                    acc_next = acc_reg + {5'd0, step_reg};
                end
                else
                begin
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            shift_reg <= 4'd1;
            div_reg <= 5'd1;
        end
        else
        begin
            state_reg <= state_next;
            shift_reg <= shift_next;
            div_reg <= div_next;
        end
    end

    // Hold datapath values
    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        step_reg <= step_next;
        acc_reg <= acc_next;
    end

    `ASSERT_IMP(a_start_idle, clk, rst_n, start, state_reg == C_IDLE)
    `ASSERT_NXT(a_start_pre, clk, rst_n, start, state_reg == C_PRE)
    `ASSERT_IMP(a_div_range, clk, rst_n, done, (div_reg >= 5'd1) && (div_reg <= DIVISOR_MAX_L))

endmodule

// ----- design/sdci_phase_ctrl.sv -----
// ----------------------------------------------------------------------------
// SD card init phase control
// Holds the identification phase and card state, and plans the results
// of each accepted transaction.
// ----------------------------------------------------------------------------
module sdci_phase_ctrl (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               step,
    input  sdci_pkg::in_item_t                                 item,
    input  sdci_pkg::cfg_t                                     cfg,
    output sdci_pkg::plan_t                                    plan,
    output sdci_pkg::out_item_t [sdci_pkg::LIST_DEPTH-1:0]     list
);

    sdci_pkg::phase_t phase_reg, phase_next;
    logic        v2_reg, v2_next;
    logic        hc_reg, hc_next;
    logic [15:0] rca_reg, rca_next;
    logic [15:0] busy_reg, busy_next;
    logic [1:0]  wait_reg, wait_next;

    function automatic sdci_pkg::out_item_t act_item(input logic [2:0] action);
        sdci_pkg::out_item_t r;
        r = '0;
        r.action = action;
        return r;
    endfunction

    function automatic sdci_pkg::out_item_t cmd_item(
        input logic [5:0]  idx,
        input logic [31:0] arg,
        input logic [1:0]  kind,
        input logic        chk_idx,
        input logic        chk_crc
    );
        sdci_pkg::out_item_t r;
        r = '0;
        r.action = sdci_pkg::ACT_ISSUE_CMD;
        r.cmd_index = idx;
        r.cmd_argument = arg;
        r.response_kind = kind;
        r.check_index = chk_idx;
        r.check_crc = chk_crc;
        return r;
    endfunction

    // Decode the transaction against the current phase
    always_comb
    begin
        phase_next = phase_reg;
        v2_next = v2_reg;
        hc_next = hc_reg;
        rca_next = rca_reg;
        busy_next = busy_reg;
        wait_next = wait_reg;
        list = '0;
        plan = '0;
        plan.clk_target = cfg.ident_clock_hz;

        if (item.opcode == sdci_pkg::OP_START)
        begin
            v2_next = 1'b0;
            hc_next = 1'b0;
            rca_next = '0;
            busy_next = '0;
            wait_next = '0;
            list[0] = act_item(sdci_pkg::ACT_HOST_RESET);
            list[1] = act_item(sdci_pkg::ACT_SET_CLOCK);
            list[2] = act_item(sdci_pkg::ACT_INIT_CLOCKS);
            list[3] = cmd_item(sdci_pkg::CMD_GO_IDLE, 32'd0, sdci_pkg::RK_NONE, 1'b0, 1'b0);
            plan.count = 3'd4;
            plan.need_clk = 1'b1;
            plan.clk_slot = 2'd1;
            plan.clk_target = cfg.ident_clock_hz;
            phase_next = sdci_pkg::PH_CMD0;
        end
        else if (item.opcode == sdci_pkg::OP_TICK)
        begin
            // Count busy time through the whole op-cond loop
            if (((phase_reg == sdci_pkg::PH_APP41) || (phase_reg == sdci_pkg::PH_ACMD41) ||
                 (phase_reg == sdci_pkg::PH_RETRY)) && (busy_reg != sdci_pkg::BUSY_MS_MAX))
            begin
                busy_next = busy_reg + 16'd1;
            end
            if (phase_reg == sdci_pkg::PH_WAIT2)
            begin
                wait_next = wait_reg + 2'd1;
                if (wait_next[1])
                begin
                    phase_next = sdci_pkg::PH_CMD8;
                    list[0] = cmd_item(sdci_pkg::CMD_SEND_IF_COND, sdci_pkg::IF_COND_ARG,
                                       sdci_pkg::RK_48, 1'b1, 1'b1);
                    plan.count = 3'd1;
                end
            end
            else if (phase_reg == sdci_pkg::PH_RETRY)
            begin
                phase_next = sdci_pkg::PH_APP41;
                list[0] = cmd_item(sdci_pkg::CMD_APP_CMD, {rca_reg, 16'h0000},
                                   sdci_pkg::RK_48, 1'b1, 1'b1);
                plan.count = 3'd1;
            end
        end
        else if (item.opcode == sdci_pkg::OP_RESULT)
        begin
            unique case (phase_reg)
                sdci_pkg::PH_CMD0:
                begin
                    if (item.cmd_failed)
                    begin
                        phase_next = sdci_pkg::PH_FAILED;
                        list[0] = act_item(sdci_pkg::ACT_FAILED);
                        plan.count = 3'd1;
                    end
                    else
                    begin
                        wait_next = '0;
                        phase_next = sdci_pkg::PH_WAIT2;
                    end
                end
                sdci_pkg::PH_CMD8:
                begin
                    if (!item.cmd_failed && (item.response_word[7:0] != sdci_pkg::CHECK_PATTERN))
                    begin
                        phase_next = sdci_pkg::PH_FAILED;
                        list[0] = act_item(sdci_pkg::ACT_FAILED);
                        plan.count = 3'd1;
                    end
                    else if (item.cmd_failed)
                    begin
                        // Version 1 card: clear the command line and drop HCS
                        v2_next = 1'b0;
                        busy_next = '0;
                        phase_next = sdci_pkg::PH_APP41;
                        list[0] = act_item(sdci_pkg::ACT_CMD_LINE_RESET);
                        list[1] = cmd_item(sdci_pkg::CMD_APP_CMD, {rca_reg, 16'h0000},
                                           sdci_pkg::RK_48, 1'b1, 1'b1);
                        plan.count = 3'd2;
                    end
                    else
                    begin
                        v2_next = 1'b1;
                        busy_next = '0;
                        phase_next = sdci_pkg::PH_APP41;
                        list[0] = cmd_item(sdci_pkg::CMD_APP_CMD, {rca_reg, 16'h0000},
                                           sdci_pkg::RK_48, 1'b1, 1'b1);
                        plan.count = 3'd1;
                    end
                end
                sdci_pkg::PH_APP41:
                begin
                    if (item.cmd_failed)
                    begin
                        phase_next = sdci_pkg::PH_FAILED;
                        list[0] = act_item(sdci_pkg::ACT_FAILED);
                    end
                    else
                    begin
                        phase_next = sdci_pkg::PH_ACMD41;
                        list[0] = cmd_item(sdci_pkg::CMD_SEND_OP_COND,
                                           {8'd0, cfg.voltage_window} |
                                           (v2_reg ? sdci_pkg::OCR_CCS : 32'd0),
                                           sdci_pkg::RK_48, 1'b0, 1'b0);
                    end
                    plan.count = 3'd1;
                end
                sdci_pkg::PH_ACMD41:
                begin
                    if (item.cmd_failed)
                    begin
                        phase_next = sdci_pkg::PH_FAILED;
                        list[0] = act_item(sdci_pkg::ACT_FAILED);
                        plan.count = 3'd1;
                    end
                    else if (item.response_word[sdci_pkg::OCR_READY_BIT])
                    begin
                        hc_next = item.response_word[sdci_pkg::OCR_CCS_BIT];
                        phase_next = sdci_pkg::PH_CMD2;
                        list[0] = cmd_item(sdci_pkg::CMD_ALL_SEND_CID, 32'd0,
                                           sdci_pkg::RK_136, 1'b0, 1'b1);
                        plan.count = 3'd1;
                    end
                    else if (busy_reg >= cfg.op_cond_timeout_ms)
                    begin
                        phase_next = sdci_pkg::PH_FAILED;
                        list[0] = act_item(sdci_pkg::ACT_FAILED);
                        plan.count = 3'd1;
                    end
                    else
                    begin
                        phase_next = sdci_pkg::PH_RETRY;
                    end
                end
                sdci_pkg::PH_CMD2:
                begin
                    if (item.cmd_failed)
                    begin
                        phase_next = sdci_pkg::PH_FAILED;
                        list[0] = act_item(sdci_pkg::ACT_FAILED);
                    end
                    else
                    begin
                        phase_next = sdci_pkg::PH_CMD3;
                        list[0] = cmd_item(sdci_pkg::CMD_SEND_RCA, 32'd0,
                                           sdci_pkg::RK_48, 1'b1, 1'b1);
                    end
                    plan.count = 3'd1;
                end
                sdci_pkg::PH_CMD3:
                begin
                    if (item.cmd_failed)
                    begin
                        phase_next = sdci_pkg::PH_FAILED;
                        list[0] = act_item(sdci_pkg::ACT_FAILED);
                    end
                    else
                    begin
                        rca_next = item.response_word[31:16];
                        phase_next = sdci_pkg::PH_CMD7;
                        list[0] = cmd_item(sdci_pkg::CMD_SELECT_CARD,
                                           {item.response_word[31:16], 16'h0000},
                                           sdci_pkg::RK_48_BUSY, 1'b1, 1'b1);
                    end
                    plan.count = 3'd1;
                end
                sdci_pkg::PH_CMD7:
                begin
                    if (item.cmd_failed)
                    begin
                        phase_next = sdci_pkg::PH_FAILED;
                        list[0] = act_item(sdci_pkg::ACT_FAILED);
                    end
                    else
                    begin
                        phase_next = sdci_pkg::PH_APP6;
                        list[0] = cmd_item(sdci_pkg::CMD_APP_CMD, {rca_reg, 16'h0000},
                                           sdci_pkg::RK_48, 1'b1, 1'b1);
                    end
                    plan.count = 3'd1;
                end
                sdci_pkg::PH_APP6:
                begin
                    // A failed APP_CMD keeps the 1-bit bus and moves on
                    if (item.cmd_failed)
                    begin
                        phase_next = sdci_pkg::PH_CMD16;
                        list[0] = cmd_item(sdci_pkg::CMD_SET_BLOCKLEN, {20'd0, cfg.block_length},
                                           sdci_pkg::RK_48, 1'b1, 1'b1);
                    end
                    else
                    begin
                        phase_next = sdci_pkg::PH_ACMD6;
                        list[0] = cmd_item(sdci_pkg::CMD_SET_BUS_WIDTH, sdci_pkg::BUS_WIDTH4_ARG,
                                           sdci_pkg::RK_48, 1'b1, 1'b1);
                    end
                    plan.count = 3'd1;
                end
                sdci_pkg::PH_ACMD6:
                begin
                    phase_next = sdci_pkg::PH_CMD16;
                    if (item.cmd_failed)
                    begin
                        list[0] = cmd_item(sdci_pkg::CMD_SET_BLOCKLEN, {20'd0, cfg.block_length},
                                           sdci_pkg::RK_48, 1'b1, 1'b1);
                        plan.count = 3'd1;
                    end
                    else
                    begin
                        list[0] = act_item(sdci_pkg::ACT_WIDTH4);
                        list[1] = cmd_item(sdci_pkg::CMD_SET_BLOCKLEN, {20'd0, cfg.block_length},
                                           sdci_pkg::RK_48, 1'b1, 1'b1);
                        plan.count = 3'd2;
                    end
                end
                sdci_pkg::PH_CMD16:
                begin
                    // Block length result is ignored; switch to transfer clock
                    phase_next = sdci_pkg::PH_DONE;
                    list[0] = act_item(sdci_pkg::ACT_SET_CLOCK);
                    list[1] = act_item(sdci_pkg::ACT_DONE);
                    list[1].high_capacity = hc_reg;
                    list[1].card_address = rca_reg;
                    plan.count = 3'd2;
                    plan.need_clk = 1'b1;
                    plan.clk_slot = 2'd0;
                    plan.clk_target = cfg.transfer_clock_hz;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Advance card state on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sdci_pkg::PH_IDLE;
            v2_reg <= 1'b0;
            hc_reg <= 1'b0;
            rca_reg <= '0;
            busy_reg <= '0;
            wait_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            v2_reg <= v2_next;
            hc_reg <= hc_next;
            rca_reg <= rca_next;
            busy_reg <= busy_next;
            wait_reg <= wait_next;
        end
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SD card init sequencer testbench
// Sends start, command-result, tick and unused-opcode transactions through the item channel,
// predicts the host actions for each one and compares every result field.
// Several clock, window, timeout and block length settings are programmed
// between drained phases, the extremes among them.
// ----------------------------------------------------------------------------
module tb_top;
    import sdci_pkg::*;

    // Codes the package leaves out
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_ready;
    in_item_t             item = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    out_item_t            result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    // Card sequencing state as the host sees it
    cfg_t        card_cfg;
    phase_t      card_phase;
    logic        card_v2;
    logic        card_hc;
    logic [15:0] card_rca;
    logic [15:0] busy_ms;
    logic [1:0]  tick_count;

    in_item_t  pending_items[$];
    out_item_t expected_actions[$];
    int        queued_count = 0;
    int        accepted_count = 0;
    int        stimulus_count = 0;
    int        error_count = 0;
    int        send_gap = 0;
    int        ready_hold = 0;
    bit        send_burst = 1'b0;
    bit        ready_burst = 1'b0;

    sd_card_init_sequencer_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Action prediction
    // ------------------------------------------------------------------------
    function automatic out_item_t plain_action(logic [2:0] act);
        out_item_t a;
        a = '0;
        a.action = act;
        return a;
    endfunction

    function automatic out_item_t command_action(logic [5:0] idx, logic [31:0] arg,
                                                 logic [1:0] kind, logic ci, logic cc);
        out_item_t a;
        a = plain_action(ACT_ISSUE_CMD);
        a.cmd_index = idx;
        a.cmd_argument = arg;
        a.response_kind = kind;
        a.check_index = ci;
        a.check_crc = cc;
        return a;
    endfunction

    // Double the prescaler, then count up the divisor, until the card clock
    // no longer exceeds the target or the search limit is reached
    function automatic out_item_t clock_action(logic [31:0] target);
        out_item_t   a;
        logic [31:0] bus;
        logic [8:0]  pre;
        logic [4:0]  div;
        bus = card_cfg.bus_clock_hz;
        pre = 9'd2;
        div = 5'd1;
        while (pre < 9'd256 && (bus / pre) > target)
            pre = pre << 1;
        while (div < 5'd16 && ((bus / pre) / div) > target)
            div = div + 5'd1;
        a = plain_action(ACT_SET_CLOCK);
        a.clock_prescaler = pre;
        a.clock_divisor = div;
        return a;
    endfunction

    function automatic out_item_t give_up();
        card_phase = PH_FAILED;
        return plain_action(ACT_FAILED);
    endfunction

    function automatic out_item_t app_command(phase_t next);
        card_phase = next;
        return command_action(CMD_APP_CMD, {card_rca, 16'h0000}, RK_48, 1'b1, 1'b1);
    endfunction

    function automatic out_item_t blocklen_command();
        card_phase = PH_CMD16;
        return command_action(CMD_SET_BLOCKLEN, {20'd0, card_cfg.block_length}, RK_48,
                              1'b1, 1'b1);
    endfunction

    // Advance the card sequence by one transaction and queue its actions
    function automatic void predict_actions(in_item_t it);
        out_item_t acts[$];
        out_item_t a;
        case (it.opcode)
            OP_START:
            begin
                card_v2 = 1'b0;
                card_hc = 1'b0;
                card_rca = '0;
                busy_ms = '0;
                tick_count = '0;
                acts.push_back(plain_action(ACT_HOST_RESET));
                acts.push_back(clock_action({6'd0, card_cfg.ident_clock_hz}));
                acts.push_back(plain_action(ACT_INIT_CLOCKS));
                acts.push_back(command_action(CMD_GO_IDLE, '0, RK_NONE, 1'b0, 1'b0));
                card_phase = PH_CMD0;
            end
            OP_TICK:
            begin
                // busy time runs during the whole op-cond loop, saturating
                if ((card_phase == PH_APP41 || card_phase == PH_ACMD41 ||
                     card_phase == PH_RETRY) && busy_ms != BUSY_MS_MAX)
                    busy_ms = busy_ms + 16'd1;
                if (card_phase == PH_WAIT2)
                begin
                    tick_count = tick_count + 2'd1;
                    if (tick_count >= 2'd2)
                    begin
                        card_phase = PH_CMD8;
                        acts.push_back(command_action(CMD_SEND_IF_COND, IF_COND_ARG, RK_48,
                                                      1'b1, 1'b1));
                    end
                end
                else if (card_phase == PH_RETRY)
                    acts.push_back(app_command(PH_APP41));
            end
            OP_RESULT:
            begin
                case (card_phase)
                    PH_CMD0:
                    begin
                        if (it.cmd_failed)
                            acts.push_back(give_up());
                        else
                        begin
                            tick_count = '0;
                            card_phase = PH_WAIT2;
                        end
                    end
                    PH_CMD8:
                    begin
                        // a timed-out CMD8 marks a v1 card; a bad echo is fatal
                        if (!it.cmd_failed && it.response_word[7:0] != CHECK_PATTERN)
                            acts.push_back(give_up());
                        else
                        begin
                            card_v2 = !it.cmd_failed;
                            if (it.cmd_failed)
                                acts.push_back(plain_action(ACT_CMD_LINE_RESET));
                            busy_ms = '0;
                            acts.push_back(app_command(PH_APP41));
                        end
                    end
                    PH_APP41:
                    begin
                        if (it.cmd_failed)
                            acts.push_back(give_up());
                        else
                        begin
                            card_phase = PH_ACMD41;
                            acts.push_back(command_action(CMD_SEND_OP_COND,
                                {8'd0, card_cfg.voltage_window} | (card_v2 ? OCR_CCS : 32'd0),
                                RK_48, 1'b0, 1'b0));
                        end
                    end
                    PH_ACMD41:
                    begin
                        if (it.cmd_failed)
                            acts.push_back(give_up());
                        else if (it.response_word[OCR_READY_BIT])
                        begin
                            card_hc = it.response_word[OCR_CCS_BIT];
                            card_phase = PH_CMD2;
                            acts.push_back(command_action(CMD_ALL_SEND_CID, '0, RK_136,
                                                          1'b0, 1'b1));
                        end
                        else if (busy_ms >= card_cfg.op_cond_timeout_ms)
                            acts.push_back(give_up());
                        else
                            card_phase = PH_RETRY;
                    end
                    PH_CMD2:
                    begin
                        if (it.cmd_failed)
                            acts.push_back(give_up());
                        else
                        begin
                            card_phase = PH_CMD3;
                            acts.push_back(command_action(CMD_SEND_RCA, '0, RK_48, 1'b1, 1'b1));
                        end
                    end
                    PH_CMD3:
                    begin
                        if (it.cmd_failed)
                            acts.push_back(give_up());
                        else
                        begin
                            card_rca = it.response_word[31:16];
                            card_phase = PH_CMD7;
                            acts.push_back(command_action(CMD_SELECT_CARD, {card_rca, 16'h0000},
                                                          RK_48_BUSY, 1'b1, 1'b1));
                        end
                    end
                    PH_CMD7:
                    begin
                        if (it.cmd_failed)
                            acts.push_back(give_up());
                        else
                            acts.push_back(app_command(PH_APP6));
                    end
                    PH_APP6:
                    begin
                        // width failures fall back to a 1-bit bus
                        if (it.cmd_failed)
                            acts.push_back(blocklen_command());
                        else
                        begin
                            card_phase = PH_ACMD6;
                            acts.push_back(command_action(CMD_SET_BUS_WIDTH, BUS_WIDTH4_ARG,
                                                          RK_48, 1'b1, 1'b1));
                        end
                    end
                    PH_ACMD6:
                    begin
                        if (!it.cmd_failed)
                            acts.push_back(plain_action(ACT_WIDTH4));
                        acts.push_back(blocklen_command());
                    end
                    PH_CMD16:
                    begin
                        acts.push_back(clock_action({6'd0, card_cfg.transfer_clock_hz}));
                        a = plain_action(ACT_DONE);
                        a.high_capacity = card_hc;
                        a.card_address = card_rca;
                        acts.push_back(a);
                        card_phase = PH_DONE;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
        foreach (acts[i])
        begin
            a = acts[i];
            a.last = (i == acts.size() - 1);
            expected_actions.push_back(a);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result comparison
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    function automatic void compare_action(out_item_t got);
        out_item_t want;
        if (expected_actions.size() == 0)
        begin
            $display("%0t: result expected none, got %h", $time, got);
            error_count++;
            return;
        end
        want = expected_actions.pop_front();
        check_field("action", want.action, got.action);
        check_field("cmd_index", want.cmd_index, got.cmd_index);
        check_field("cmd_argument", want.cmd_argument, got.cmd_argument);
        check_field("response_kind", want.response_kind, got.response_kind);
        check_field("check_index", want.check_index, got.check_index);
        check_field("check_crc", want.check_crc, got.check_crc);
        check_field("clock_prescaler", want.clock_prescaler, got.clock_prescaler);
        check_field("clock_divisor", want.clock_divisor, got.clock_divisor);
        check_field("high_capacity", want.high_capacity, got.high_capacity);
        check_field("card_address", want.card_address, got.card_address);
        check_field("last", want.last, got.last);
    endfunction

    // ------------------------------------------------------------------------
    // Item driver: predict on each accepted transaction, then hold off or
    // present the next pending item
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                predict_actions(item);
                accepted_count++;
            end
            if (!item_valid || item_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    item_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    item <= pending_items.pop_front();
                    item_valid <= 1'b1;
                    if ($urandom_range(0, 39) == 0)
                        send_burst = !send_burst;
                    send_gap = send_burst ? 0 : $urandom_range(0, 11);
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: check each result, then stall for a drawn count
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (result_valid && result_ready)
            begin
                compare_action(result);
                if ($urandom_range(0, 39) == 0)
                    ready_burst = !ready_burst;
                ready_hold = ready_burst ? 0 : $urandom_range(0, 11);
            end
            else if (ready_hold > 0)
                ready_hold--;
            result_ready <= (ready_hold == 0);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic void queue_item(logic [1:0] op, logic failed, logic [31:0] resp,
                                       bit counted);
        in_item_t it;
        it.opcode = op;
        it.cmd_failed = failed;
        it.response_word = resp;
        pending_items.push_back(it);
        queued_count++;
        if (counted)
            stimulus_count++;
    endfunction

    // Queue a command result; now and then break the sequence with a failure
    // or a restart, or slip an ignorable transaction in ahead of it
    function automatic bit queue_result(logic [31:0] resp);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll == 0)
        begin
            queue_item(OP_RESULT, 1'b1, resp, 1'b1);
            return 1'b1;
        end
        if (roll == 1)
        begin
            queue_item(OP_START, 1'($urandom_range(0, 1)), $urandom, 1'b1);
            return 1'b1;
        end
        if (roll < 8)
            queue_item((roll < 5) ? OP_TICK : OP_UNUSED, 1'($urandom_range(0, 1)),
                       $urandom, 1'b0);
        queue_item(OP_RESULT, 1'b0, resp, 1'b1);
        return 1'b0;
    endfunction

    // One identification run with random responses
    task automatic queue_init_sequence();
        int          busy_rounds;
        int          cmd8_kind;
        logic [31:0] resp;
        logic [7:0]  flip;
        queue_item(OP_START, 1'($urandom_range(0, 1)), $urandom, 1'b1);
        if (queue_result($urandom))
            return;
        queue_item(OP_TICK, 1'($urandom_range(0, 1)), $urandom, 1'b1);
        queue_item(OP_TICK, 1'($urandom_range(0, 1)), $urandom, 1'b1);
        // CMD8: v1 card, bad check pattern or proper echo
        cmd8_kind = $urandom_range(0, 7);
        resp = $urandom;
        if (cmd8_kind == 0)
            queue_item(OP_RESULT, 1'b1, resp, 1'b1);
        else if (cmd8_kind == 1)
        begin
            flip = $urandom_range(1, 255);
            resp[7:0] = CHECK_PATTERN ^ flip;
            queue_item(OP_RESULT, 1'b0, resp, 1'b1);
            return;
        end
        else
        begin
            resp[7:0] = CHECK_PATTERN;
            if (queue_result(resp))
                return;
        end
        // op-cond loop: busy answers, each retried on the next tick
        busy_rounds = $urandom_range(0, 4);
        repeat (busy_rounds)
        begin
            if (queue_result($urandom))
                return;
            resp = $urandom;
            resp[OCR_READY_BIT] = 1'b0;
            if (queue_result(resp))
                return;
            queue_item(OP_TICK, 1'($urandom_range(0, 1)), $urandom, 1'b1);
        end
        if (queue_result($urandom))
            return;
        resp = $urandom;
        resp[OCR_READY_BIT] = 1'b1;
        if (queue_result(resp))
            return;
        // CMD2, CMD3 with the RCA in the upper half, CMD7
        repeat (3)
        begin
            if (queue_result($urandom))
                return;
        end
        // bus width step may fail on either command without ending the run
        if ($urandom_range(0, 4) == 0)
            queue_item(OP_RESULT, 1'b1, $urandom, 1'b1);
        else
        begin
            queue_item(OP_RESULT, 1'b0, $urandom, 1'b1);
            queue_item(OP_RESULT, 1'($urandom_range(0, 3) == 0), $urandom, 1'b1);
        end
        // CMD16 outcome does not matter
        queue_item(OP_RESULT, 1'($urandom_range(0, 1)), $urandom, 1'b1);
    endtask

    task automatic queue_directed();
        // ignored while idle
        queue_item(OP_UNUSED, 1'b1, 32'hFFFF_FFFF, 1'b0);
        queue_item(OP_TICK, 1'b0, 32'h0, 1'b0);
        // start, then restart during the 2 ms wait
        queue_item(OP_START, 1'b0, 32'h0, 1'b1);
        queue_item(OP_RESULT, 1'b0, 32'h0, 1'b1);
        queue_item(OP_TICK, 1'b0, 32'h0, 1'b1);
        queue_item(OP_START, 1'b1, 32'hFFFF_FFFF, 1'b1);
        queue_item(OP_RESULT, 1'b0, 32'hFFFF_FFFF, 1'b1);
        queue_item(OP_TICK, 1'b1, 32'hFFFF_FFFF, 1'b1);
        queue_item(OP_TICK, 1'b0, 32'h0, 1'b1);
        // v1 card: CMD8 times out, one busy round, then ready with CCS
        queue_item(OP_RESULT, 1'b1, 32'h0, 1'b1);
        queue_item(OP_RESULT, 1'b0, 32'h0, 1'b1);
        queue_item(OP_RESULT, 1'b0, 32'h7FFF_FFFF, 1'b1);
        queue_item(OP_TICK, 1'b0, 32'h0, 1'b1);
        queue_item(OP_RESULT, 1'b0, 32'h0, 1'b1);
        queue_item(OP_RESULT, 1'b0, 32'hFFFF_FFFF, 1'b1);
        // CMD2, CMD3 with an all-ones RCA, CMD7
        queue_item(OP_RESULT, 1'b0, 32'h0, 1'b1);
        queue_item(OP_RESULT, 1'b0, 32'hFFFF_0000, 1'b1);
        queue_item(OP_RESULT, 1'b0, 32'h0, 1'b1);
        // CMD55 fails, so the bus stays 1-bit; CMD16 failure is ignored
        queue_item(OP_RESULT, 1'b1, 32'h0, 1'b1);
        queue_item(OP_RESULT, 1'b1, 32'hFFFF_FFFF, 1'b1);
        // nothing pending once done
        queue_item(OP_RESULT, 1'b0, 32'h0, 1'b0);
        // wrong CMD8 check pattern
        queue_item(OP_START, 1'b0, 32'h0, 1'b1);
        queue_item(OP_RESULT, 1'b0, 32'h0, 1'b1);
        queue_item(OP_TICK, 1'b0, 32'h0, 1'b1);
        queue_item(OP_TICK, 1'b0, 32'h0, 1'b1);
        queue_item(OP_RESULT, 1'b0, 32'h0000_01AB, 1'b1);
    endtask

    // Hold until every item is accepted and answered, then let the block settle
    task automatic wait_idle();
        while (accepted_count != queued_count || expected_actions.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Keep valid high across back-to-back writes; the caller drops it
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_BUS_CLOCK:       card_cfg.bus_clock_hz = data;
            CFG_IDENT_CLOCK:     card_cfg.ident_clock_hz = data[25:0];
            CFG_TRANSFER_CLOCK:  card_cfg.transfer_clock_hz = data[25:0];
            CFG_VOLTAGE_WINDOW:  card_cfg.voltage_window = data[23:0];
            CFG_OP_COND_TIMEOUT: card_cfg.op_cond_timeout_ms = data[15:0];
            CFG_BLOCK_LENGTH:    card_cfg.block_length = data[11:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic configure(int setting);
        logic [31:0] bus;
        logic [31:0] ident;
        logic [31:0] xfer;
        logic [31:0] window;
        logic [31:0] limit_ms;
        logic [31:0] blen;
        case (setting)
            0:
            begin
                bus = 32'hFFFF_FFFF;
                ident = 32'd50_000_000;
                xfer = 32'd50_000_000;
                window = 32'h00FF_FFFF;
                limit_ms = 32'd65535;
                blen = 32'd2048;
            end
            1:
            begin
                bus = 32'd1;
                ident = 32'd1;
                xfer = 32'd1;
                window = 32'd0;
                limit_ms = 32'd1;
                blen = 32'd1;
            end
            2:
            begin
                // upper bits drop off, leaving zero clock targets
                bus = 32'd600_000_000;
                ident = 32'h0400_0000;
                xfer = 32'hFC00_0000;
                window = 32'hFF12_3456;
                limit_ms = 32'hFFFF_0003;
                blen = 32'hFFFF_F000;
            end
            default:
            begin
                bus = $urandom;
                ident = $urandom_range(1, 50_000_000);
                xfer = $urandom_range(1, 50_000_000);
                window = $urandom & 32'h00FF_FFFF;
                limit_ms = $urandom_range(1, 6);
                blen = $urandom_range(1, 2048);
            end
        endcase
        write_register(CFG_BUS_CLOCK, bus);
        write_register(CFG_IDENT_CLOCK, ident);
        write_register(CFG_TRANSFER_CLOCK, xfer);
        write_register(CFG_VOLTAGE_WINDOW, window);
        write_register(CFG_OP_COND_TIMEOUT, limit_ms);
        write_register(CFG_BLOCK_LENGTH, blen);
        if (setting == 2)
            write_register(CFG_UNUSED, $urandom);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int goal;
        card_cfg.bus_clock_hz = BUS_CLOCK_RST;
        card_cfg.ident_clock_hz = IDENT_CLOCK_RST;
        card_cfg.transfer_clock_hz = TRANSFER_CLOCK_RST;
        card_cfg.voltage_window = VOLTAGE_WINDOW_RST;
        card_cfg.op_cond_timeout_ms = OP_COND_TIMEOUT_RST;
        card_cfg.block_length = BLOCK_LENGTH_RST;
        card_phase = PH_IDLE;
        card_v2 = 1'b0;
        card_hc = 1'b0;
        card_rca = '0;
        busy_ms = '0;
        tick_count = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        queue_directed();
        wait_idle();
        // each setting starts from a drained block
        for (int setting = 0; setting < 7; setting++)
        begin
            configure(setting);
            goal = stimulus_count + 55;
            while (stimulus_count < goal)
                queue_init_sequence();
            wait_idle();
        end
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
